// ===== rtl/core/tst_pkg.sv =====
package tst_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned IdW   = 15;
  localparam int unsigned DataW = 16;
  localparam int unsigned ElapW = 16;

  localparam logic [IdW-1:0] IdTop   = 15'h7FFF;
  localparam logic [IdW-1:0] IdFirst = 15'd1;

  typedef enum logic [1:0] {
    ACT_ADD     = 2'd0,
    ACT_REMOVE  = 2'd1,
    ACT_ADVANCE = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    KIND_ADDED     = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_REMOVED   = 3'd2,
    KIND_NOT_FOUND = 3'd3,
    KIND_EXPIRED   = 3'd4,
    KIND_DONE      = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_MV,
    S_ADD_NEW,
    S_RM_RD,
    S_RM_CHK,
    S_RM_MV,
    S_ADV_RD,
    S_ADV_WR,
    S_EX_RD,
    S_EX_CHK,
    S_EX_MV,
    S_MF_RD,
    S_MF_CMP,
    S_MF_SW,
    S_MF_W0,
    S_MF_W1
  } state_e;

  typedef struct packed {
    logic [TimeW-1:0] rem;
    logic [IdW-1:0]   id;
    logic [DataW-1:0] data;
  } entry_t;

endpackage

// ===== rtl/core/tst_if.sv =====
interface tst_in_if;
  import tst_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       action;
  logic [TimeW-1:0] delay_ticks;
  logic [DataW-1:0] user_data;
  logic [IdW-1:0]   target_id;
  logic [ElapW-1:0] elapsed_ticks;

  modport source (output valid, action, delay_ticks, user_data, target_id, elapsed_ticks,
                  input ready);
  modport sink (input valid, action, delay_ticks, user_data, target_id, elapsed_ticks,
                output ready);
endinterface

interface tst_out_if #(parameter int unsigned CNT_W = 5);
  import tst_pkg::*;
  logic             valid;
  logic             ready;
  logic [2:0]       kind;
  logic [IdW-1:0]   timer_id;
  logic [DataW-1:0] timer_data;
  logic [TimeW-1:0] next_due;
  logic [CNT_W-1:0] active_count;
  logic             last;

  modport source (output valid, kind, timer_id, timer_data, next_due, active_count, last,
                  input ready);
  modport sink (input valid, kind, timer_id, timer_data, next_due, active_count, last,
                output ready);
endinterface

// ===== rtl/core/tst_mem.sv =====
module tst_mem
  import tst_pkg::*;
#(
  parameter int unsigned Depth = 16,
  parameter int unsigned IdxW  = 4
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  entry_t          wdata_i,
  input  logic [IdxW-1:0] raddr_i,
  output entry_t          rdata_o
);

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/tst_cmp.sv =====
module tst_cmp
  import tst_pkg::*;
(
  input  logic [TimeW-1:0] a_i,
  input  logic [TimeW-1:0] b_i,
  output logic             lt_o,
  output logic [TimeW-1:0] sub_sat_o
);

  // One subtractor gives both the compare and the saturated difference.
  logic [TimeW:0] diff;

  assign diff      = {1'b0, a_i} - {1'b0, b_i};
  assign lt_o      = diff[TimeW];
  assign sub_sat_o = diff[TimeW] ? '0 : diff[TimeW-1:0];

endmodule

// ===== rtl/core/software_timer_table.sv =====
// An add that does not take slot 0 writes the new entry at the end when it is taken; one that
// does moves slot 0 to the end, then writes the new entry into slot 0. A remove searches the
// slots in turn and moves the last entry into the freed slot; when slot 0 goes, it rescans for
// the minimum and swaps it into slot 0. An advance runs a saturating subtract pass, a scan that
// swap-removes each expiry, and a re-selection of the minimum. One transaction at a time: the
// next one is taken the cycle after the final result is taken. The table memory, one write port
// and one registered read port, is read one entry per cycle. Each result waits until it is taken.
// Reset clears the count, the id counter (to one) and all control state; table contents are kept.
module software_timer_table
  import tst_pkg::*;
#(
  parameter int unsigned MAX_TIMERS = 16,
  parameter int unsigned CntW       = 5
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tst_in_if.sink     in_i,
  tst_out_if.source  out_o
);

  localparam int unsigned IdxW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_TIMERS);

  // Sequencer state and counters.
  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]   zeros_q, zeros_d;
  logic [IdW-1:0]    last_id_q, last_id_d;
  logic [TimeW-1:0]  front_q, front_d;
  logic [TimeW-1:0]  minnz_q, minnz_d;
  entry_t            best_q, best_d;
  logic [IdxW-1:0]   best_idx_q, best_idx_d;
  logic              in_ready;

  // Latched transaction fields.
  action_e           act_q, act_d;
  logic [TimeW-1:0]  delay_q, delay_d;
  logic [DataW-1:0]  data_q, data_d;
  logic [IdW-1:0]    target_q, target_d;
  logic [ElapW-1:0]  elapsed_q, elapsed_d;
  entry_t            exp_q, exp_d;

  // Result register.
  logic              out_valid_q, out_valid_d;
  kind_e             out_kind_q, out_kind_d;
  logic [IdW-1:0]    out_id_q, out_id_d;
  logic [DataW-1:0]  out_data_q, out_data_d;
  logic [TimeW-1:0]  out_due_q, out_due_d;
  logic [CntW-1:0]   out_cnt_q, out_cnt_d;
  logic              out_last_q, out_last_d;
  state_e            ret_q, ret_d;

  // Memory port and shared unit.
  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr, mem_raddr;
  entry_t            mem_wdata, rdata;
  logic [TimeW-1:0]  cmp_a, cmp_b, cmp_sub;
  logic              cmp_lt;

  logic              emit;
  kind_e             e_kind;
  logic [IdW-1:0]    e_id;
  logic [DataW-1:0]  e_data;
  logic [TimeW-1:0]  e_due;
  logic              e_last;
  state_e            e_ret;

  logic [CntW-1:0]   cnt_m1;
  logic [CntW-1:0]   zeros_m1;
  entry_t            new_e;

  tst_mem #(
    .Depth (MAX_TIMERS),
    .IdxW  (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  tst_cmp u_cmp (
    .a_i       (cmp_a),
    .b_i       (cmp_b),
    .lt_o      (cmp_lt),
    .sub_sat_o (cmp_sub)
  );

  assign cnt_m1   = count_q - CntW'(1);
  assign zeros_m1 = zeros_q - CntW'(1);
  assign in_ready = (state_q == S_IDLE) && !out_valid_q;
  assign new_e    = '{rem: delay_q, id: last_id_q, data: data_q};

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    zeros_d    = zeros_q;
    last_id_d  = last_id_q;
    front_d    = front_q;
    minnz_d    = minnz_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    act_d      = act_q;
    delay_d    = delay_q;
    data_d     = data_q;
    target_d   = target_q;
    elapsed_d  = elapsed_q;
    exp_d      = exp_q;
    ret_d      = ret_q;

    out_valid_d = out_valid_q;
    out_kind_d  = out_kind_q;
    out_id_d    = out_id_q;
    out_data_d  = out_data_q;
    out_due_d   = out_due_q;
    out_cnt_d   = out_cnt_q;
    out_last_d  = out_last_q;

    mem_we    = 1'b0;
    mem_waddr = idx_q[IdxW-1:0];
    mem_wdata = rdata;
    mem_raddr = idx_q[IdxW-1:0];
    cmp_a     = rdata.rem;
    cmp_b     = best_q.rem;

    emit   = 1'b0;
    e_kind = KIND_DONE;
    e_id   = '0;
    e_data = '0;
    e_due  = '0;
    e_last = 1'b1;
    e_ret  = S_IDLE;

    // While a result is held, the sequencer waits for it to be taken.
    if (out_valid_q) begin
      if (out_o.ready) begin
        out_valid_d = 1'b0;
        state_d     = ret_q;
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          cmp_a = in_i.delay_ticks;
          cmp_b = front_q;
          if (in_i.valid) begin
            act_d     = action_e'(in_i.action);
            delay_d   = in_i.delay_ticks;
            data_d    = in_i.user_data;
            target_d  = in_i.target_id;
            elapsed_d = in_i.elapsed_ticks;
            idx_d     = '0;
            unique case (action_e'(in_i.action))
              ACT_ADD: begin
                if (count_q >= CntMax) begin
                  emit   = 1'b1;
                  e_kind = KIND_FULL;
                  e_due  = (count_q != '0) ? front_q : '0;
                end else begin
                  last_id_d = (last_id_q == IdTop) ? IdFirst : last_id_q + IdW'(1);
                  if (count_q == '0 || cmp_lt) begin
                    mem_raddr = '0;
                    state_d   = S_ADD_MV;
                  end else begin
                    mem_we    = 1'b1;
                    mem_waddr = count_q[IdxW-1:0];
                    mem_wdata = '{rem: in_i.delay_ticks, id: last_id_d, data: in_i.user_data};
                    count_d   = count_q + CntW'(1);
                    emit      = 1'b1;
                    e_kind    = KIND_ADDED;
                    e_id      = last_id_d;
                    e_due     = front_q;
                  end
                end
              end
              ACT_REMOVE: state_d = S_RM_RD;
              ACT_ADVANCE: begin
                zeros_d = '0;
                minnz_d = '1;
                state_d = S_ADV_RD;
              end
              default: state_d = S_IDLE;
            endcase
          end
        end

        // Add, earlier than the front: slot 0 moves to the end, unless the table is empty.
        S_ADD_MV: begin
          if (count_q != '0) begin
            mem_we    = 1'b1;
            mem_waddr = count_q[IdxW-1:0];
            mem_wdata = rdata;
          end
          state_d = S_ADD_NEW;
        end
        S_ADD_NEW: begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = new_e;
          count_d   = count_q + CntW'(1);
          front_d   = delay_q;
          emit      = 1'b1;
          e_kind    = KIND_ADDED;
          e_id      = last_id_q;
          e_due     = delay_q;
        end

        S_RM_RD: begin
          if (idx_q >= count_q) begin
            emit   = 1'b1;
            e_kind = KIND_NOT_FOUND;
            e_id   = target_q;
            e_due  = (count_q != '0) ? front_q : '0;
          end else begin
            state_d = S_RM_CHK;
          end
        end
        S_RM_CHK: begin
          if (rdata.id == target_q) begin
            mem_raddr = cnt_m1[IdxW-1:0];
            state_d   = S_RM_MV;
          end else begin
            idx_d   = idx_q + CntW'(1);
            state_d = S_RM_RD;
          end
        end
        S_RM_MV: begin
          mem_we  = 1'b1;
          count_d = cnt_m1;
          if (idx_q == '0 && cnt_m1 != '0) begin
            state_d = S_MF_RD;
          end else begin
            emit   = 1'b1;
            e_kind = KIND_REMOVED;
            e_id   = target_q;
            e_due  = (cnt_m1 != '0) ? front_q : '0;
          end
        end

        // Advance, first pass: saturating subtract, counting zeros and the nonzero minimum.
        S_ADV_RD: begin
          if (idx_q >= count_q) begin
            idx_d   = '0;
            state_d = S_EX_RD;
          end else begin
            state_d = S_ADV_WR;
          end
        end
        S_ADV_WR: begin
          cmp_b         = {{(TimeW-ElapW){1'b0}}, elapsed_q};
          mem_we        = 1'b1;
          mem_wdata     = rdata;
          mem_wdata.rem = cmp_sub;
          if (cmp_sub == '0) begin
            zeros_d = zeros_q + CntW'(1);
          end else if (cmp_sub < minnz_q) begin
            minnz_d = cmp_sub;
          end
          idx_d   = idx_q + CntW'(1);
          state_d = S_ADV_RD;
        end

        // Advance, second pass: swap-remove every expired entry in scan order.
        S_EX_RD: begin
          if (idx_q >= count_q) begin
            if (count_q != '0) begin
              idx_d   = '0;
              state_d = S_MF_RD;
            end else begin
              emit   = 1'b1;
              e_kind = KIND_DONE;
            end
          end else begin
            state_d = S_EX_CHK;
          end
        end
        S_EX_CHK: begin
          if (rdata.rem == '0) begin
            exp_d     = rdata;
            mem_raddr = cnt_m1[IdxW-1:0];
            state_d   = S_EX_MV;
          end else begin
            idx_d   = idx_q + CntW'(1);
            state_d = S_EX_RD;
          end
        end
        S_EX_MV: begin
          mem_we  = 1'b1;
          count_d = cnt_m1;
          zeros_d = zeros_m1;
          emit    = 1'b1;
          e_kind  = KIND_EXPIRED;
          e_id    = exp_q.id;
          e_data  = exp_q.data;
          e_due   = (zeros_m1 != '0 || cnt_m1 == '0) ? '0 : minnz_q;
          e_last  = 1'b0;
          e_ret   = S_EX_RD;
        end

        // Minimum re-selection: scan all occupied slots, then swap the earliest into slot 0.
        S_MF_RD: state_d = S_MF_CMP;
        S_MF_CMP: begin
          if (idx_q == '0 || cmp_lt) begin
            best_d     = rdata;
            best_idx_d = idx_q[IdxW-1:0];
          end
          if (idx_q == cnt_m1) begin
            state_d = S_MF_SW;
          end else begin
            idx_d   = idx_q + CntW'(1);
            state_d = S_MF_RD;
          end
        end
        S_MF_SW: begin
          if (best_idx_q == '0) begin
            front_d = best_q.rem;
            emit    = 1'b1;
            e_kind  = (act_q == ACT_REMOVE) ? KIND_REMOVED : KIND_DONE;
            e_id    = (act_q == ACT_REMOVE) ? target_q : '0;
            e_due   = best_q.rem;
          end else begin
            mem_raddr = '0;
            state_d   = S_MF_W0;
          end
        end
        S_MF_W0: begin
          mem_we    = 1'b1;
          mem_waddr = best_idx_q;
          mem_wdata = rdata;
          state_d   = S_MF_W1;
        end
        S_MF_W1: begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = best_q;
          front_d   = best_q.rem;
          emit      = 1'b1;
          e_kind    = (act_q == ACT_REMOVE) ? KIND_REMOVED : KIND_DONE;
          e_id      = (act_q == ACT_REMOVE) ? target_q : '0;
          e_due     = best_q.rem;
        end
        default: state_d = S_IDLE;
      endcase

      if (emit) begin
        out_valid_d = 1'b1;
        out_kind_d  = e_kind;
        out_id_d    = e_id;
        out_data_d  = e_data;
        out_due_d   = e_due;
        out_cnt_d   = count_d;
        out_last_d  = e_last;
        ret_d       = e_ret;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      last_id_q   <= IdFirst;
      out_valid_q <= 1'b0;
      ret_q       <= S_IDLE;
      idx_q       <= '0;
      zeros_q     <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      last_id_q   <= last_id_d;
      out_valid_q <= out_valid_d;
      ret_q       <= ret_d;
      idx_q       <= idx_d;
      zeros_q     <= zeros_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q    <= front_d;
    minnz_q    <= minnz_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    act_q      <= act_d;
    delay_q    <= delay_d;
    data_q     <= data_d;
    target_q   <= target_d;
    elapsed_q  <= elapsed_d;
    exp_q      <= exp_d;
    out_kind_q <= out_kind_d;
    out_id_q   <= out_id_d;
    out_data_q <= out_data_d;
    out_due_q  <= out_due_d;
    out_cnt_q  <= out_cnt_d;
    out_last_q <= out_last_d;
  end

  assign in_i.ready         = in_ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = out_kind_q;
  assign out_o.timer_id     = out_id_q;
  assign out_o.timer_data   = out_data_q;
  assign out_o.next_due     = out_due_q;
  assign out_o.active_count = out_cnt_q;
  assign out_o.last         = out_last_q;

  // The table never holds more timers than it has slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntMax)
    else $error("timer count exceeds table size");

  // A new transaction is never taken while a result is still pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(in_ready && out_valid_q))
    else $error("input accepted with a result pending");

  // The id counter never produces the reserved id zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni) last_id_q != '0)
    else $error("id counter reached zero");

  // Each expiry is followed by more results; the closing result of an advance ends it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == KIND_EXPIRED) |-> !out_last_q)
    else $error("expiry marked as final result");

endmodule
